[rtl/psdr_pkg.sv]
// shared constants and types for the path slash and dot reducer
`default_nettype none
package psdr_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // results one item can cause, and depth of the result queue
  localparam int RES_MAX = 3;
  localparam int QDEPTH  = 4;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int RCNT_W  = $clog2(RES_MAX + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       path_end;
  } res_t;

endpackage
`default_nettype wire

[rtl/path_slash_dot_reducer.sv]
// path slash and dot reducer: streaming filter with a four-entry result queue
// the results of a taken item are registered into the queue; the queue head drives the output
// throughput: one item per cycle while no item yields over one result and out_stall is low;
//   an item that yields two or three results leaves them queued to be offered in order
// the result queue takes a new item whenever three entries are free after this cycle's pop
// reset: synchronous, active low; empties the queue and returns to the start of a path
`default_nettype none
module path_slash_dot_reducer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_no_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_ch,
  output logic            out_has_char,
  output logic            out_path_end
);
  import psdr_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_ONE, PH_TWO, PH_BODY} phase_t;

  phase_t                  phase_r, phase_nxt;
  logic                    slash_r, slash_nxt;
  logic                    dot_r, dot_nxt;
  res_t                    q_r [QDEPTH];
  res_t                    q_nxt [QDEPTH];
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;

  res_t                    res [RES_MAX];
  logic [RCNT_W-1:0]       n_res;
  logic                    body;
  logic                    is_sl, is_dot;
  logic                    in_acc, pop;
  logic [QCNT_W-1:0]       base;
  logic [QCNT_W-1:0]       k;
  logic [QCNT_W-1:0]       src;

  assign is_sl  = (in_ch == CH_SLASH);
  assign is_dot = (in_ch == CH_DOT);
  assign pop    = (cnt_r != '0) && !out_stall;
  assign in_stall = !((cnt_r <= QCNT_W'(QDEPTH - RES_MAX)) ||
                      ((cnt_r == QCNT_W'(QDEPTH - RES_MAX + 1)) && pop));
  assign in_acc = in_valid && !in_stall;

  // results and next path state for the item at the input
  always_comb begin
    phase_nxt = phase_r;
    slash_nxt = slash_r;
    dot_nxt   = dot_r;
    n_res     = '0;
    body      = 1'b0;
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = '{ch: CH_NUL, has_char: 1'b0, path_end: 1'b0};
    end
    if (!in_no_char) begin
      case (phase_r)
        PH_START: begin
          if (is_sl) begin
            res[n_res] = '{ch: CH_SLASH, has_char: 1'b1, path_end: 1'b0};
            n_res      = n_res + RCNT_W'(1);
            slash_nxt  = 1'b1;
            phase_nxt  = PH_ONE;
          end else begin
            phase_nxt = PH_BODY;
            body      = 1'b1;
          end
        end
        PH_ONE: begin
          if (is_sl) begin
            phase_nxt = PH_TWO;
          end else begin
            phase_nxt = PH_BODY;
            body      = 1'b1;
          end
        end
        PH_TWO: begin
          phase_nxt = PH_BODY;
          body      = 1'b1;
          if (!is_sl) begin
            res[n_res] = '{ch: CH_SLASH, has_char: 1'b1, path_end: 1'b0};
            n_res      = n_res + RCNT_W'(1);
          end
        end
        default: body = 1'b1;
      endcase
      if (body) begin
        if (dot_nxt) begin
          dot_nxt = 1'b0;
          if (!is_sl) begin
            res[n_res] = '{ch: CH_DOT, has_char: 1'b1, path_end: 1'b0};
            n_res      = n_res + RCNT_W'(1);
            res[n_res] = '{ch: in_ch, has_char: 1'b1, path_end: 1'b0};
            n_res      = n_res + RCNT_W'(1);
            slash_nxt  = 1'b0;
          end
        end else if (slash_nxt) begin
          if (is_dot) begin
            dot_nxt = 1'b1;
          end else if (!is_sl) begin
            res[n_res] = '{ch: in_ch, has_char: 1'b1, path_end: 1'b0};
            n_res      = n_res + RCNT_W'(1);
            slash_nxt  = 1'b0;
          end
        end else begin
          res[n_res] = '{ch: in_ch, has_char: 1'b1, path_end: 1'b0};
          n_res      = n_res + RCNT_W'(1);
          slash_nxt  = is_sl;
        end
      end
    end
    if (in_last) begin
      if (phase_nxt == PH_TWO) begin
        res[n_res] = '{ch: CH_SLASH, has_char: 1'b1, path_end: 1'b0};
        n_res      = n_res + RCNT_W'(1);
      end
      if (dot_nxt) begin
        res[n_res] = '{ch: CH_DOT, has_char: 1'b1, path_end: 1'b0};
        n_res      = n_res + RCNT_W'(1);
      end
      if (n_res == '0) begin
        res[0] = '{ch: CH_NUL, has_char: 1'b0, path_end: 1'b0};
        n_res  = RCNT_W'(1);
      end
      res[n_res - RCNT_W'(1)].path_end = 1'b1;
      phase_nxt = PH_START;
      slash_nxt = 1'b0;
      dot_nxt   = 1'b0;
    end
  end

  // result queue: drop the head on a pop, append the new item's results behind
  always_comb begin
    base = cnt_r - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      src      = QCNT_W'(i) + QCNT_W'(pop);
      k        = QCNT_W'(i) - base;
      q_nxt[i] = q_r[i];
      if (QCNT_W'(i) < base) begin
        q_nxt[i] = q_r[src[QIDX_W-1:0]];
      end else if (in_acc && (k < QCNT_W'(n_res))) begin
        q_nxt[i] = res[k[RCNT_W-1:0]];
      end
    end
    cnt_nxt = base + (in_acc ? QCNT_W'(n_res) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      slash_r <= 1'b0;
      dot_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        phase_r <= phase_nxt;
        slash_r <= slash_nxt;
        dot_r   <= dot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_valid    = (cnt_r != '0);
  assign out_ch       = q_r[0].ch;
  assign out_has_char = q_r[0].has_char;
  assign out_path_end = q_r[0].path_end;

endmodule
`default_nettype wire

[rtl/psdr_checker.sv]
// port checks for the path slash and dot reducer, bound to the top level
`default_nettype none
module psdr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_ch,
  input wire logic       out_has_char,
  input wire logic       out_path_end
);
  import psdr_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a bare end marker always closes a path and carries a zero byte
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_char) |-> (out_path_end && (out_ch == CH_NUL)))
    else $error("bare end marker malformed");

  // a path end taken while the output is idle shows a result the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last && !out_valid) |=> out_valid)
    else $error("path end not followed by a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_ch) && $stable(out_has_char) && $stable(out_path_end)))
    else $error("stalled result changed");

endmodule

bind path_slash_dot_reducer psdr_checker u_psdr_checker (.*);
`default_nettype wire
